// ===== hdl/maze_dfs_goal_search_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef MAZE_DFS_GOAL_SEARCH_ASSERT_SVH
`define MAZE_DFS_GOAL_SEARCH_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MDGS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("maze search assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MDGS_ASSERT_NXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("maze search assertion failed");

`endif

// ===== hdl/mdgs_pkg.sv =====
package mdgs_pkg;

    localparam int MAX_SIDE_DEF = 64;

    typedef logic [2:0] t_mark;

    localparam t_mark M_EMPTY = 3'd0;
    localparam t_mark M_WALL  = 3'd1;
    localparam t_mark M_GOAL  = 3'd2;
    localparam t_mark M_VISIT = 3'd3;
    localparam t_mark M_ROUTE = 3'd4;
    localparam t_mark M_FOUND = 3'd5;

    localparam logic [1:0] F_WRITE = 2'd0;
    localparam logic [1:0] F_RUN   = 2'd1;
    localparam logic [1:0] F_READ  = 2'd2;

    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_GOAL  = 2'd2;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_GOALS  = 2'd2;

    typedef struct packed {
        logic accept;
        logic run_clear;
        logic wr_cell;
        logic rd_result;
        logic sweep_init;
        logic sweep_merge;
        logic sweep_fail;
        logic sl_issue;
        logic sl_take;
        logic turn;
        logic bk_issue;
        logic bk_take;
        logic goal_take;
        logic set_ok;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       sweep_done;
        logic       step_ok;
        logic       m_pass;
        logic       m_goal;
        logic       tries3;
        logic       at_origin;
        logic       goals_met;
        logic       out_free;
    } t_status;

    // Folds one working-map mark into the result map.
    function automatic t_mark merge_mark(input t_mark w, input t_mark s, input logic with_route);
        t_mark m;
        m = s;
        if (w == M_ROUTE) begin
            if (with_route && s != M_GOAL) m = M_ROUTE;
        end else if (w == M_VISIT && s != M_ROUTE && s != M_GOAL) begin
            m = M_VISIT;
        end
        return m;
    endfunction

    function automatic t_mark read_mark(input t_mark m);
        return (m == M_FOUND) ? M_GOAL : m;
    endfunction

endpackage

// ===== hdl/mdgs_ram.sv =====
module mdgs_ram #(
    parameter int W = 3,
    parameter int D = 4096
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic                 i_re,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/mdgs_ctrl.sv =====
module mdgs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mdgs_pkg::t_status i_status,
    output mdgs_pkg::t_cmd    o_cmd,
    output logic              o_in_stall
);
    import mdgs_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'h001,
        S_DECODE = 12'h002,
        S_INIT   = 12'h004,
        S_CHECK  = 12'h008,
        S_SLIDE  = 12'h010,
        S_SLWAIT = 12'h020,
        S_TURN   = 12'h040,
        S_BKWAIT = 12'h080,
        S_GOAL   = 12'h100,
        S_MERGE  = 12'h200,
        S_FAIL   = 12'h400,
        S_EMIT   = 12'h800
    } t_state;

    t_state r_state, n_state;
    t_cmd   cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.accept = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                case (i_status.func)
                    F_WRITE: begin
                        cmd.wr_cell = 1'b1;
                        n_state     = S_EMIT;
                    end
                    F_RUN: begin
                        cmd.run_clear = 1'b1;
                        n_state       = S_INIT;
                    end
                    F_READ: begin
                        cmd.rd_result = 1'b1;
                        n_state       = S_EMIT;
                    end
                    default: n_state = S_EMIT;
                endcase
            end
            S_INIT: begin
                cmd.sweep_init = 1'b1;
                if (i_status.sweep_done) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.goals_met) begin
                    cmd.set_ok = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_state = S_SLIDE;
                end
            end
            S_SLIDE: begin
                if (i_status.step_ok) begin
                    cmd.sl_issue = 1'b1;
                    n_state      = S_SLWAIT;
                end else begin
                    n_state = S_TURN;
                end
            end
            S_SLWAIT: begin
                cmd.sl_take = 1'b1;
                if (i_status.m_goal) n_state = S_GOAL;
                else if (i_status.m_pass) n_state = S_SLIDE;
                else n_state = S_TURN;
            end
            S_TURN: begin
                if (i_status.tries3) begin
                    if (i_status.at_origin) begin
                        n_state = S_FAIL;
                    end else begin
                        cmd.bk_issue = 1'b1;
                        n_state      = S_BKWAIT;
                    end
                end else begin
                    cmd.turn = 1'b1;
                    n_state  = S_SLIDE;
                end
            end
            S_BKWAIT: begin
                cmd.bk_take = 1'b1;
                n_state     = S_SLIDE;
            end
            S_GOAL: begin
                cmd.goal_take = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                cmd.sweep_merge = 1'b1;
                if (i_status.sweep_done) n_state = S_CHECK;
            end
            S_FAIL: begin
                cmd.sweep_fail = 1'b1;
                if (i_status.sweep_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != S_IDLE);
endmodule

// ===== hdl/mdgs_dp.sv =====
module mdgs_dp #(
    parameter int MAX_SIDE = mdgs_pkg::MAX_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mdgs_pkg::t_cmd    i_cmd,
    output mdgs_pkg::t_status o_status,
    input  logic [1:0]        i_func,
    input  logic [5:0]        i_col,
    input  logic [5:0]        i_row,
    input  logic [1:0]        i_cell_kind,
    input  logic              i_cfg_valid,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [2:0]        o_cell_mark,
    output logic              o_success,
    output logic [7:0]        o_goals_found
);
    import mdgs_pkg::*;

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int AW    = 2 * CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [1:0] DIR_E = 2'd0;
    localparam logic [1:0] DIR_S = 2'd1;
    localparam logic [1:0] DIR_W = 2'd2;

    logic [6:0]    r_width, r_height;
    logic [7:0]    r_goals;
    logic [1:0]    r_func, r_kind;
    logic [5:0]    r_col, r_row;
    logic [CW-1:0] r_rat_c, r_rat_r;
    logic [1:0]    r_head, r_tries;
    logic [7:0]    r_found;
    logic          r_ok;
    logic [AW:0]   r_cnt;
    logic          r_pv;
    logic [AW-1:0] r_paddr;
    logic          r_out_valid, r_out_succ;
    logic [2:0]    r_out_mark;
    logic [7:0]    r_out_goals;

    logic [CW:0]   eff_w, eff_h;
    logic          in_grid;
    logic [AW-1:0] in_addr, cur_addr, nxt_addr;
    logic [2*CW:0] nxt, bck;
    logic [1:0]    back_dir;
    logic          sw_any, sw_issue, out_free, move;

    logic          pr_we, pr_re, wk_we, wk_re, rs_we, rs_re, cf_we, cf_re, st_we, st_re;
    logic [AW-1:0] wk_waddr, wk_raddr, rs_raddr, st_waddr;
    logic [1:0]    pr_wdata, pr_rd, cf_rd;
    t_mark         wk_wdata, rs_wdata, st_wdata, wk_rd, rs_rd, st_rd, pr_mark;

    // Returns {in bounds, new row, new column} for one step in direction d.
    function automatic logic [2*CW:0] step(input logic [1:0] d, input logic [CW-1:0] c,
                                           input logic [CW-1:0] r,
                                           input logic [CW:0] lim_w,
                                           input logic [CW:0] lim_h);
        logic [CW:0]   c1, r1;
        logic          ok;
        logic [CW-1:0] nc, nr;
        c1 = {1'b0, c} + (CW+1)'(1);
        r1 = {1'b0, r} + (CW+1)'(1);
        nc = c;
        nr = r;
        case (d)
            DIR_E: begin
                ok = c1 < lim_w;
                nc = c1[CW-1:0];
            end
            DIR_S: begin
                ok = r1 < lim_h;
                nr = r1[CW-1:0];
            end
            DIR_W: begin
                ok = (c != '0);
                nc = c - CW'(1);
            end
            default: begin
                ok = (r != '0);
                nr = r - CW'(1);
            end
        endcase
        return {ok, nr, nc};
    endfunction

    always_comb begin
        if (r_width == '0) eff_w = (CW+1)'(1);
        else if (int'(r_width) > MAX_SIDE) eff_w = (CW+1)'(MAX_SIDE);
        else eff_w = (CW+1)'(r_width);
        if (r_height == '0) eff_h = (CW+1)'(1);
        else if (int'(r_height) > MAX_SIDE) eff_h = (CW+1)'(MAX_SIDE);
        else eff_h = (CW+1)'(r_height);
    end

    assign in_grid  = (int'(r_col) < MAX_SIDE) && (int'(r_row) < MAX_SIDE);
    assign in_addr  = {CW'(r_row), CW'(r_col)};
    assign cur_addr = {r_rat_r, r_rat_c};
    assign nxt      = step(r_head, r_rat_c, r_rat_r, eff_w, eff_h);
    assign nxt_addr = nxt[2*CW-1:0];
    assign back_dir = cf_rd + 2'd2;
    assign bck      = step(back_dir, r_rat_c, r_rat_r, eff_w, eff_h);
    assign move     = i_cmd.sl_take && (wk_rd == M_EMPTY || wk_rd == M_FOUND || wk_rd == M_GOAL);

    assign sw_any   = i_cmd.sweep_init | i_cmd.sweep_merge | i_cmd.sweep_fail;
    assign sw_issue = sw_any && !r_cnt[AW];
    assign out_free = !r_out_valid || !i_out_stall;
    assign pr_mark  = {1'b0, pr_rd};

    always_comb begin
        pr_we    = i_cmd.wr_cell && in_grid;
        pr_wdata = (r_kind == KIND_EMPTY) ? 2'(M_EMPTY) :
                   (r_kind == KIND_GOAL) ? 2'(M_GOAL) : 2'(M_WALL);
        pr_re    = sw_issue && i_cmd.sweep_init;

        wk_re    = i_cmd.sl_issue | i_cmd.bk_issue |
                   (sw_issue && (i_cmd.sweep_merge || i_cmd.sweep_fail));
        wk_raddr = i_cmd.sl_issue ? nxt_addr : i_cmd.bk_issue ? cur_addr : r_cnt[AW-1:0];
        wk_we    = 1'b0;
        wk_waddr = r_paddr;
        wk_wdata = M_ROUTE;
        if (move) begin
            wk_we    = 1'b1;
            wk_waddr = nxt_addr;
            wk_wdata = (wk_rd == M_GOAL) ? M_FOUND : M_ROUTE;
        end else if (i_cmd.bk_take) begin
            wk_we    = (wk_rd != M_EMPTY);
            wk_waddr = cur_addr;
            wk_wdata = M_VISIT;
        end else if (r_pv && (i_cmd.sweep_init || i_cmd.sweep_merge)) begin
            wk_we    = 1'b1;
            if (r_paddr == '0) wk_wdata = M_ROUTE;
            else wk_wdata = i_cmd.sweep_init ? pr_mark : st_rd;
        end

        rs_re    = i_cmd.rd_result | (sw_issue && (i_cmd.sweep_merge || i_cmd.sweep_fail));
        rs_raddr = i_cmd.rd_result ? in_addr : r_cnt[AW-1:0];
        rs_we    = r_pv && sw_any;
        if (i_cmd.sweep_init) rs_wdata = pr_mark;
        else if (i_cmd.sweep_merge) rs_wdata = merge_mark(wk_rd, rs_rd, 1'b1);
        else if (r_found == '0) rs_wdata = wk_rd;
        else rs_wdata = merge_mark(wk_rd, rs_rd, 1'b0);

        cf_we    = move;
        cf_re    = i_cmd.bk_issue;

        st_we    = i_cmd.goal_take | (r_pv && i_cmd.sweep_init);
        st_waddr = i_cmd.goal_take ? cur_addr : r_paddr;
        st_wdata = i_cmd.goal_take ? M_FOUND : pr_mark;
        st_re    = sw_issue && i_cmd.sweep_merge;
    end

    mdgs_ram #(.W(2), .D(DEPTH)) u_pristine (
        .i_clk(i_clk), .i_we(pr_we), .i_waddr(in_addr), .i_wdata(pr_wdata),
        .i_re(pr_re), .i_raddr(r_cnt[AW-1:0]), .o_rdata(pr_rd)
    );
    mdgs_ram #(.W(3), .D(DEPTH)) u_working (
        .i_clk(i_clk), .i_we(wk_we), .i_waddr(wk_waddr), .i_wdata(wk_wdata),
        .i_re(wk_re), .i_raddr(wk_raddr), .o_rdata(wk_rd)
    );
    mdgs_ram #(.W(3), .D(DEPTH)) u_result (
        .i_clk(i_clk), .i_we(rs_we), .i_waddr(r_paddr), .i_wdata(rs_wdata),
        .i_re(rs_re), .i_raddr(rs_raddr), .o_rdata(rs_rd)
    );
    mdgs_ram #(.W(2), .D(DEPTH)) u_came (
        .i_clk(i_clk), .i_we(cf_we), .i_waddr(nxt_addr), .i_wdata(r_head),
        .i_re(cf_re), .i_raddr(cur_addr), .o_rdata(cf_rd)
    );
    mdgs_ram #(.W(3), .D(DEPTH)) u_start (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_wdata),
        .i_re(st_re), .i_raddr(r_cnt[AW-1:0]), .o_rdata(st_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 7'd64;
            r_height    <= 7'd64;
            r_goals     <= 8'd1;
            r_rat_c     <= '0;
            r_rat_r     <= '0;
            r_head      <= '0;
            r_tries     <= '0;
            r_found     <= '0;
            r_ok        <= 1'b0;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[6:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[6:0];
                    CFG_GOALS:  r_goals  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.accept) r_ok <= 1'b0;
            if (i_cmd.run_clear) begin
                r_rat_c <= '0;
                r_rat_r <= '0;
                r_head  <= '0;
                r_tries <= '0;
                r_found <= '0;
            end
            if (move) begin
                r_rat_c <= nxt[CW-1:0];
                r_rat_r <= nxt[2*CW-1:CW];
                r_tries <= '0;
            end
            if (i_cmd.turn) begin
                r_tries <= r_tries + 2'd1;
                r_head  <= r_head + 2'd1;
            end
            if (i_cmd.bk_issue) r_tries <= '0;
            if (i_cmd.bk_take) begin
                r_head <= '0;
                if (bck[2*CW]) begin
                    r_rat_c <= bck[CW-1:0];
                    r_rat_r <= bck[2*CW-1:CW];
                end
            end
            if (i_cmd.goal_take) begin
                r_found <= r_found + 8'd1;
                r_head  <= '0;
                r_rat_c <= '0;
                r_rat_r <= '0;
            end
            if (i_cmd.set_ok) r_ok <= 1'b1;

            r_pv  <= sw_issue;
            r_cnt <= !sw_any ? '0 : sw_issue ? r_cnt + (AW+1)'(1) : r_cnt;

            if (i_cmd.emit) r_out_valid <= 1'b1;
            else if (!i_out_stall) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_paddr <= r_cnt[AW-1:0];
        if (i_cmd.accept) begin
            r_func <= i_func;
            r_col  <= i_col;
            r_row  <= i_row;
            r_kind <= i_cell_kind;
        end
        if (i_cmd.emit) begin
            r_out_mark  <= (r_func == F_READ && in_grid) ? read_mark(rs_rd) : M_EMPTY;
            r_out_succ  <= (r_func == F_RUN) && r_ok;
            r_out_goals <= (r_func == F_RUN) ? r_found : 8'd0;
        end
    end

    always_comb begin
        o_status            = '0;
        o_status.func       = r_func;
        o_status.sweep_done = sw_any && r_cnt[AW] && !r_pv;
        o_status.step_ok    = nxt[2*CW];
        o_status.m_pass     = (wk_rd == M_EMPTY) || (wk_rd == M_FOUND);
        o_status.m_goal     = (wk_rd == M_GOAL);
        o_status.tries3     = (r_tries == 2'd3);
        o_status.at_origin  = (r_rat_c == '0) && (r_rat_r == '0);
        o_status.goals_met  = (r_found >= r_goals);
        o_status.out_free   = out_free;
    end

    assign o_out_valid   = r_out_valid;
    assign o_cell_mark   = r_out_mark;
    assign o_success     = r_out_succ;
    assign o_goals_found = r_out_goals;
endmodule

// ===== hdl/maze_dfs_goal_search.sv =====
// Grid maze goal search by depth-first walk.
// Input channel (i_in_valid / o_in_stall) takes one command word: func selects
// write cell, run search, read cell mark or no operation; col, row and
// cell_kind go with it. Every command word gives exactly one result word on the
// output channel (o_out_valid / i_out_stall): cell_mark for reads, success and
// goals_found for runs, zeros otherwise.
// Configuration (i_cfg_valid / o_cfg_ready, always ready) sets width, height
// and goal count; write it only while the block is idle.
// A write, read or no-op passes through the decode and emit states to the
// output register. A run sweeps the whole map memory (MAX_SIDE rounded up
// to a power of two, squared; 4096 cells at the default) to load the maps,
// then steps the rat cell by cell with blocked steps, turns and back-ups in
// between, and sweeps once more for every goal reached and for a failing
// finish. Those sweeps set the run time.
// One command is in flight at a time; the next word is taken once the result
// sits in the output register, even while the receiver stalls it. A result
// waiting behind a stalled output holds the block until that slot frees.
// Reset clears control and the configuration to 64 x 64 with one goal; the
// map memories are not cleared and must be loaded before a run.
module maze_dfs_goal_search #(
    parameter int MAX_SIDE = mdgs_pkg::MAX_SIDE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_func,
    input  logic [5:0] i_col,
    input  logic [5:0] i_row,
    input  logic [1:0] i_cell_kind,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_cell_mark,
    output logic       o_success,
    output logic [7:0] o_goals_found,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import mdgs_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The controller sequences the walk; the datapath owns maps and counters.
    mdgs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    mdgs_dp #(.MAX_SIDE(MAX_SIDE)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (i_func),
        .i_col         (i_col),
        .i_row         (i_row),
        .i_cell_kind   (i_cell_kind),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_cell_mark   (o_cell_mark),
        .o_success     (o_success),
        .o_goals_found (o_goals_found)
    );

    // Registers are always writable; the user must write them only while idle.
    assign o_cfg_ready = 1'b1;
endmodule

// ===== hdl/mdgs_check.sv =====
`include "maze_dfs_goal_search_assert.svh"
module mdgs_check (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_cell_mark,
    input logic       o_success,
    input logic [7:0] o_goals_found
);
    // A stalled result word stays offered.
    `MDGS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    // Only one command is in flight: the cycle after a word is taken, input stalls.
    `MDGS_ASSERT_NXT(a_one_cmd, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)
    // A read result carries no run status, and a run result carries no mark.
    `MDGS_ASSERT_IMP(a_mark_only, i_clk, i_rst_n, o_out_valid && o_cell_mark != 3'd0,
                     !o_success && o_goals_found == 8'd0)
endmodule

bind maze_dfs_goal_search mdgs_check u_check (.*);

// ===== verif/maze_dfs_goal_search_tb.sv =====
module maze_dfs_goal_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mdgs_pkg::*;

    localparam int SIDE  = 64;
    localparam int CELLS = SIDE * SIDE;
    localparam logic [1:0] F_NOP     = 2'd3;
    localparam logic [1:0] KIND_WALL = 2'd1;
    localparam logic [1:0] KIND_ODD  = 2'd3;

    typedef struct {
        logic [1:0] func;
        logic [5:0] col;
        logic [5:0] row;
        logic [1:0] kind;
    } t_cmd_word;

    typedef struct {
        logic [2:0] mark;
        logic       ok;
        logic [7:0] goals;
    } t_result_word;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_func;
    logic [5:0] i_col;
    logic [5:0] i_row;
    logic [1:0] i_cell_kind;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_cell_mark;
    logic       o_success;
    logic [7:0] o_goals_found;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    maze_dfs_goal_search u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_col        (i_col),
        .i_row        (i_row),
        .i_cell_kind  (i_cell_kind),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_cell_mark  (o_cell_mark),
        .o_success    (o_success),
        .o_goals_found(o_goals_found),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // The clock runs at a 12 ns period.
    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    // Command words waiting to be driven, and result words still owed by the block.
    t_cmd_word    cmd_backlog[$];
    t_result_word owed_results[$];
    t_cmd_word    cur_cmd;
    int           err_cnt = 0;

    // Idle percentages of the two channels; they only change while the block is idle.
    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;

    // Long receiver hold-off: the stimulus process flips hold_kick, and the hold
    // process then keeps the output stalled for a fixed number of cycles.
    bit hold_kick = 1'b0;
    bit hold_seen = 1'b0;
    int hold_cnt  = 0;

    // ------------------------------------------------------------------
    // Shadow maze. It mirrors the loaded grid, the start map, the walk's working
    // copy, the merged result map and the heading each cell was entered with.
    // ------------------------------------------------------------------
    t_mark      sh_pristine[CELLS];
    t_mark      sh_work[CELLS];
    t_mark      sh_result[CELLS];
    t_mark      sh_start[CELLS];
    logic [1:0] sh_came[CELLS];
    int         rat_c, rat_r, rat_dir, rat_tries, goals_hit;
    int         used_w, used_h;
    logic [6:0] reg_width  = 7'd64;
    logic [6:0] reg_height = 7'd64;
    logic [7:0] reg_goals  = 8'd1;

    function automatic int clamp_side(input logic [6:0] v);
        if (v < 1) return 1;
        if (v > SIDE) return SIDE;
        return int'(v);
    endfunction

    // One step in heading d: 0 east, 1 south, 2 west, 3 north.
    // Returns 0 when the step would leave the area in use.
    function automatic bit step_cell(input int d, input int c, input int r,
                                     output int nc, output int nr);
        int cc, rr;
        cc = c;
        rr = r;
        case (d & 3)
            0: cc++;
            1: rr++;
            2: cc--;
            default: rr--;
        endcase
        nc = cc;
        nr = rr;
        return !(cc < 0 || rr < 0 || cc >= used_w || rr >= used_h);
    endfunction

    // Slides the rat straight ahead; returns 1 when it enters a goal not yet found.
    function automatic bit slide_rat();
        int nc, nr, idx;
        t_mark m;
        while (step_cell(rat_dir, rat_c, rat_r, nc, nr)) begin
            idx = nr * SIDE + nc;
            m = sh_work[idx];
            if (m == M_EMPTY || m == M_FOUND) sh_work[idx] = M_ROUTE;
            else if (m == M_GOAL) sh_work[idx] = M_FOUND;
            else return 1'b0;
            sh_came[idx] = rat_dir[1:0];
            rat_c = nc;
            rat_r = nr;
            rat_tries = 0;
            if (m == M_GOAL) return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void back_up_rat();
        int nc, nr, idx;
        idx = rat_r * SIDE + rat_c;
        if (sh_work[idx] != M_EMPTY) sh_work[idx] = M_VISIT;
        if (step_cell((sh_came[idx] + 2) & 3, rat_c, rat_r, nc, nr)) begin
            rat_c = nc;
            rat_r = nr;
        end
    endfunction

    function automatic void fold_walk(input bit keep_route);
        t_mark w, s;
        for (int i = 0; i < CELLS; i++) begin
            w = sh_work[i];
            s = sh_result[i];
            if (w == M_ROUTE) begin
                if (keep_route && s != M_GOAL) sh_result[i] = M_ROUTE;
            end else if (w == M_VISIT && s != M_ROUTE && s != M_GOAL) begin
                sh_result[i] = M_VISIT;
            end
        end
    endfunction

    function automatic bit search_maze();
        used_w = clamp_side(reg_width);
        used_h = clamp_side(reg_height);
        sh_start  = sh_pristine;
        sh_work   = sh_pristine;
        sh_result = sh_pristine;
        rat_c = 0;
        rat_r = 0;
        rat_dir = 0;
        rat_tries = 0;
        goals_hit = 0;
        sh_work[0] = M_ROUTE;
        while (goals_hit < reg_goals) begin
            if (slide_rat()) begin
                goals_hit++;
                sh_start[rat_r * SIDE + rat_c] = M_FOUND;
                rat_dir = 0;
                rat_c = 0;
                rat_r = 0;
                fold_walk(1'b1);
                sh_work = sh_start;
                sh_work[0] = M_ROUTE;
            end else if (rat_tries == 3) begin
                if (rat_c == 0 && rat_r == 0) begin
                    if (goals_hit != 0) fold_walk(1'b0);
                    else sh_result = sh_work;
                    return 1'b0;
                end
                rat_tries = 0;
                back_up_rat();
                rat_dir = 0;
            end else begin
                rat_tries++;
                rat_dir = (rat_dir + 1) & 3;
            end
        end
        return 1'b1;
    endfunction

    // Works out the result word that one accepted command word must produce.
    function automatic t_result_word answer_for(input t_cmd_word w);
        t_result_word res;
        t_mark m;
        int idx;
        res = '{mark: 3'd0, ok: 1'b0, goals: 8'd0};
        idx = int'(w.row) * SIDE + int'(w.col);
        case (w.func)
            F_WRITE: begin
                if (w.kind == KIND_EMPTY) sh_pristine[idx] = M_EMPTY;
                else if (w.kind == KIND_GOAL) sh_pristine[idx] = M_GOAL;
                else sh_pristine[idx] = M_WALL;
            end
            F_RUN: begin
                res.ok = search_maze();
                res.goals = goals_hit[7:0];
            end
            F_READ: begin
                m = sh_result[idx];
                res.mark = (m == M_FOUND) ? M_GOAL : m;
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command driver. A word is predicted at the edge where it is taken;
    // the next one is offered only when the slot is free, so a stalled
    // word never changes.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) owed_results = {owed_results, answer_for(cur_cmd)};
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    cur_cmd = cmd_backlog.pop_front();
                    i_func      <= cur_cmd.func;
                    i_col       <= cur_cmd.col;
                    i_row       <= cur_cmd.row;
                    i_cell_kind <= cur_cmd.kind;
                    i_in_valid  <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // The hold process counts the long receiver hold-off on its own.
    always @(posedge i_clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen <= hold_kick;
            hold_cnt  <= 400;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    // Result monitor: each taken result word is checked against the oldest one owed.
    always @(posedge i_clk) begin
        t_result_word exp_res;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result word mark=%0d success=%0d goals=%0d",
                         $time, o_cell_mark, o_success, o_goals_found);
                err_cnt++;
            end else begin
                exp_res = owed_results.pop_front();
                if (o_cell_mark !== exp_res.mark) begin
                    $display("%0t: cell_mark expected %0d actual %0d",
                             $time, exp_res.mark, o_cell_mark);
                    err_cnt++;
                end
                if (o_success !== exp_res.ok) begin
                    $display("%0t: success expected %0d actual %0d",
                             $time, exp_res.ok, o_success);
                    err_cnt++;
                end
                if (o_goals_found !== exp_res.goals) begin
                    $display("%0t: goals_found expected %0d actual %0d",
                             $time, exp_res.goals, o_goals_found);
                    err_cnt++;
                end
            end
        end
        i_out_stall <= (hold_cnt > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Stimulus. The generator keeps its own count of goal cells so that a
    // run never costs more than a handful of full-map sweeps.
    // ------------------------------------------------------------------
    bit goal_at[CELLS];
    int goal_total = 0;
    int gen_w = 64, gen_h = 64;

    task automatic queue_cmd(input logic [1:0] func, input int col, input int row,
                             input logic [1:0] kind);
        int idx;
        idx = row * SIDE + col;
        if (func == F_WRITE) begin
            if (goal_at[idx]) goal_total--;
            goal_at[idx] = (kind == KIND_GOAL);
            if (goal_at[idx]) goal_total++;
        end
        cmd_backlog = {cmd_backlog,
                       t_cmd_word'{func: func, col: 6'(col), row: 6'(row), kind: kind}};
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_WIDTH:  reg_width  = val[6:0];
            CFG_HEIGHT: reg_height = val[6:0];
            CFG_GOALS:  reg_goals  = val;
            default: ;
        endcase
    endtask

    // Waits until every word has gone through and the block has settled.
    task automatic drain();
        while (cmd_backlog.size() != 0 || i_in_valid || owed_results.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_maze(input logic [6:0] w, input logic [6:0] h, input logic [7:0] g);
        cfg_write(CFG_WIDTH, {1'b0, w});
        cfg_write(CFG_HEIGHT, {1'b0, h});
        cfg_write(CFG_GOALS, g);
        i_cfg_valid <= 1'b0;
        gen_w = clamp_side(w);
        gen_h = clamp_side(h);
    endtask

    // Random command word: mostly cell writes and reads inside the area in use,
    // now and then a run, a no-op or an address anywhere in the top three rows.
    task automatic queue_random(input int run_pct);
        int r, c, rw;
        logic [1:0] k;
        r = $urandom_range(99);
        if ($urandom_range(9) < 7) begin
            c  = $urandom_range(gen_w - 1);
            rw = $urandom_range(gen_h - 1);
        end else begin
            c  = $urandom_range(SIDE - 1);
            rw = $urandom_range(2);
        end
        k = 2'($urandom_range(3));
        if (r < run_pct) begin
            queue_cmd(F_RUN, $urandom_range(63), $urandom_range(63), k);
        end else if (r < run_pct + 45) begin
            if (k == KIND_GOAL && goal_total >= 6) k = KIND_EMPTY;
            queue_cmd(F_WRITE, c, rw, k);
        end else if (r < run_pct + 52) begin
            queue_cmd(F_NOP, $urandom_range(63), $urandom_range(63), k);
        end else begin
            queue_cmd(F_READ, c, rw, k);
        end
    endtask

    typedef struct {
        logic [6:0] w;
        logic [6:0] h;
        logic [7:0] g;
        int         run_pct;
    } t_maze_setting;

    // Every area in use lies inside the loaded part of the grid.
    t_maze_setting settings[8] = '{
        '{7'd12,  7'd12,  8'd1,   4},
        '{7'd8,   7'd8,   8'd2,   8},
        '{7'd1,   7'd1,   8'd1,   8},
        '{7'd127, 7'd3,   8'd255, 6},
        '{7'd0,   7'd12,  8'd0,   8},
        '{7'd12,  7'd10,  8'd3,   6},
        '{7'd5,   7'd12,  8'd4,   6},
        '{7'd12,  7'd12,  8'd2,   8}
    };

    initial begin
        logic [1:0] k;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_func      = F_NOP;
        i_col       = '0;
        i_row       = '0;
        i_cell_kind = KIND_EMPTY;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WIDTH;
        i_cfg_data  = '0;
        foreach (sh_pristine[i]) begin
            sh_pristine[i] = M_EMPTY;
            sh_work[i]     = M_EMPTY;
            sh_result[i]   = M_EMPTY;
            sh_start[i]    = M_EMPTY;
            sh_came[i]     = 2'd0;
            goal_at[i]     = 1'b0;
        end
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The map memories come up undefined, so the part of the grid that any
        // walk or read touches is loaded before the first run: the top three
        // rows and the upper left 12 x 12 corner, about a third walls.
        set_maze(7'd6, 7'd4, 8'd1);
        for (int r = 0; r < 12; r++) begin
            for (int c = 0; c < SIDE; c++) begin
                if (r < 3 || c < 12) begin
                    k = ($urandom_range(9) < 3) ?
                        (($urandom_range(1) != 0) ? KIND_ODD : KIND_WALL) : KIND_EMPTY;
                    if (r == 0 && c == 0) k = KIND_EMPTY;
                    queue_cmd(F_WRITE, c, r, k);
                end
            end
        end

        // Directed words on a small 6 x 4 maze: a goal on the origin, which is
        // never counted, a goal in the far corner, a kind-three wall,
        // a goal outside the area in use and a no-op with every field high.
        queue_cmd(F_WRITE, 0, 0, KIND_GOAL);
        queue_cmd(F_WRITE, 1, 0, KIND_ODD);
        queue_cmd(F_WRITE, 5, 3, KIND_GOAL);
        queue_cmd(F_WRITE, 63, 63, KIND_GOAL);
        queue_cmd(F_RUN, 63, 63, KIND_ODD);
        queue_cmd(F_READ, 0, 0, KIND_EMPTY);
        queue_cmd(F_READ, 1, 0, KIND_EMPTY);
        queue_cmd(F_READ, 5, 3, KIND_EMPTY);
        queue_cmd(F_READ, 63, 63, KIND_ODD);
        queue_cmd(F_READ, 2, 1, KIND_EMPTY);
        queue_cmd(F_NOP, 63, 63, KIND_ODD);
        // Wall off the start so the next run gets stuck at the origin with no goal.
        queue_cmd(F_WRITE, 1, 0, KIND_WALL);
        queue_cmd(F_WRITE, 0, 1, KIND_WALL);
        queue_cmd(F_RUN, 0, 0, KIND_EMPTY);
        queue_cmd(F_READ, 0, 0, KIND_EMPTY);
        queue_cmd(F_READ, 5, 3, KIND_EMPTY);
        queue_cmd(F_READ, 0, 1, KIND_EMPTY);
        queue_cmd(F_WRITE, 1, 0, KIND_EMPTY);
        queue_cmd(F_WRITE, 0, 1, KIND_EMPTY);
        queue_cmd(F_RUN, 0, 0, KIND_EMPTY);
        queue_cmd(F_READ, 3, 2, KIND_EMPTY);
        drain();

        // Random phases. Each one rewrites all three registers and rotates
        // through the idle patterns: none, sender idle, receiver stalling, both.
        for (int p = 0; p < 8; p++) begin
            set_maze(settings[p].w, settings[p].h, settings[p].g);
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin sender_idle_pct = 19; recv_stall_pct = 19; end
            endcase
            // Give the first random run a goal to hunt for.
            queue_cmd(F_WRITE, gen_w - 1, gen_h - 1, KIND_GOAL);
            queue_cmd(F_RUN, 0, 0, KIND_EMPTY);
            for (int n = 0; n < 50; n++) queue_random(settings[p].run_pct);
            // Halfway through one phase the receiver stops for a long stretch
            // while the sender keeps offering words.
            if (p == 5) begin
                while (cmd_backlog.size() > 25) @(posedge i_clk);
                hold_kick = !hold_kick;
            end
            drain();
        end

        repeat (50) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("** maze_dfs_goal_search: PASSED **");
        end else begin
            $display("** maze_dfs_goal_search: FAILED **");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #(64'd300_000_000);
        $display("** maze_dfs_goal_search: FAILED **");
        $finish;
    end

endmodule
